@@ src/utf8_stream_decoder_top_assert.svh @@
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define U8SD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8sd assertion failed");
// Next-cycle implication, disabled during reset
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8sd assertion failed");
`else
`define U8SD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ src/u8sd_pkg.sv @@
// Package for the UTF-8 stream decoder: field widths, status codes,
// result word type and lead byte decode functions. No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 31;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int PEND_W   = 3;

    // Status codes of a result word
    localparam logic [STATUS_W-1:0] ST_CHAR  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Lead byte class masks
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] L2_MASK    = 8'hE0;
    localparam logic [BYTE_W-1:0] L2_CODE    = 8'hC0;
    localparam logic [BYTE_W-1:0] L3_MASK    = 8'hF0;
    localparam logic [BYTE_W-1:0] L3_CODE    = 8'hE0;
    localparam logic [BYTE_W-1:0] L4_MASK    = 8'hF8;
    localparam logic [BYTE_W-1:0] L4_CODE    = 8'hF0;
    localparam logic [BYTE_W-1:0] L5_MASK    = 8'hFC;
    localparam logic [BYTE_W-1:0] L5_CODE    = 8'hF8;
    localparam logic [BYTE_W-1:0] L6_MASK    = 8'hFE;
    localparam logic [BYTE_W-1:0] L6_CODE    = 8'hFC;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'o77;

    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic [POS_W-1:0]    char_position;
        logic [STATUS_W-1:0] status;
        logic                string_done;
    } res_t;

    // Sequence length of a lead byte, 1 to 6, or 0 for a non-lead byte
    function automatic logic [PEND_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [PEND_W-1:0] len;
        if ((b & ASCII_MASK) == '0)        len = 3'd1;
        else if ((b & L2_MASK) == L2_CODE) len = 3'd2;
        else if ((b & L3_MASK) == L3_CODE) len = 3'd3;
        else if ((b & L4_MASK) == L4_CODE) len = 3'd4;
        else if ((b & L5_MASK) == L5_CODE) len = 3'd5;
        else if ((b & L6_MASK) == L6_CODE) len = 3'd6;
        else                               len = 3'd0;
        return len;
    endfunction

    // Payload bits carried by a lead byte of the given length
    function automatic logic [BYTE_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                       input logic [PEND_W-1:0] len);
        logic [BYTE_W-1:0] mask;
        case (len)
            3'd1:    mask = 8'h7F;
            3'd2:    mask = 8'h1F;
            3'd3:    mask = 8'h0F;
            3'd4:    mask = 8'h07;
            3'd5:    mask = 8'h03;
            3'd6:    mask = 8'h01;
            default: mask = 8'h00;
        endcase
        return b & mask;
    endfunction

endpackage

@@ src/u8sd_in_if.sv @@
// Byte channel of the UTF-8 stream decoder: valid/ready plus one byte word.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

interface u8sd_in_if;
    import u8sd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

@@ src/u8sd_out_if.sv @@
// Character channel of the UTF-8 stream decoder: valid/ready plus result word.
// Depends on u8sd_pkg.
`timescale 1ns / 1ps

interface u8sd_out_if;
    import u8sd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CP_W-1:0]     code_point;
    logic [POS_W-1:0]    char_position;
    logic [STATUS_W-1:0] status;
    logic                string_done;

    modport source (output valid, output code_point, output char_position,
                    output status, output string_done, input ready);
    modport sink   (input valid, input code_point, input char_position,
                    input status, input string_done, output ready);
endinterface

@@ src/u8sd_core.sv @@
// Decoder state and per-byte update: pending count, accumulator, counter.
// Depends on u8sd_pkg, u8sd_in_if and the assertion macro header.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_assert.svh"

module u8sd_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    u8sd_in_if.sink        bytes,
    input  logic           space_ok,
    output logic           push,
    output u8sd_pkg::res_t push_word
);
    import u8sd_pkg::*;

    localparam int PosW = (COUNT_BITS < POS_W) ? COUNT_BITS : POS_W;

    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [CP_W-1:0]       acc_reg, acc_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic              fire;
    logic              done;
    logic [PEND_W-1:0] len;
    logic [PEND_W-1:0] pend_upd;
    logic [CP_W-1:0]   acc_upd;
    logic [COUNT_BITS-1:0] cnt_upd;

    assign bytes.ready = space_ok;
    assign fire        = bytes.valid && space_ok;
    assign len         = lead_length(bytes.in_byte);

    // Per-byte update of pending count and accumulator
    always_comb
    begin
        pend_upd = pend_reg;
        acc_upd  = acc_reg;
        done     = 1'b0;
        if (pend_reg == '0)
        begin
            if (len != '0)
            begin
                acc_upd  = CP_W'(lead_payload(bytes.in_byte, len));
                pend_upd = len - 3'd1;
                done     = (len == 3'd1);
            end
        end
        else
        begin
            acc_upd  = {acc_reg[CP_W-7:0], bytes.in_byte[5:0] & CONT_MASK[5:0]};
            pend_upd = pend_reg - 3'd1;
            done     = (pend_reg == 3'd1);
        end
    end

    // Saturating character counter
    assign cnt_upd = (done && (cnt_reg != {COUNT_BITS{1'b1}})) ?
                     cnt_reg + COUNT_BITS'(1) : cnt_reg;

    // Result word for this byte
    always_comb
    begin
        push_word.char_position = POS_W'(cnt_upd[PosW-1:0]);
        push_word.string_done   = bytes.string_end;
        if (done)
        begin
            push_word.code_point = acc_upd;
            push_word.status     = ST_CHAR;
        end
        else
        begin
            push_word.code_point = '0;
            push_word.status     = (pend_upd != '0) ? ST_TRUNC : ST_EMPTY;
        end
    end

    assign push = fire && (done || bytes.string_end);

    // Next state: string end clears everything
    always_comb
    begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (fire)
        begin
            if (bytes.string_end)
            begin
                pend_next = '0;
                acc_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                pend_next = pend_upd;
                acc_next  = acc_upd;
                cnt_next  = cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Checks
    `U8SD_ASSERT_IMPL(a_pend_range, clk, rst_n, 1'b1, pend_reg <= 3'd5)
    `U8SD_ASSERT_NEXT(a_end_clears, clk, rst_n, fire && bytes.string_end,
                      pend_reg == '0 && acc_reg == '0 && cnt_reg == '0)
    `U8SD_ASSERT_NEXT(a_idle_holds, clk, rst_n, !fire,
                      $stable(pend_reg) && $stable(acc_reg) && $stable(cnt_reg))

endmodule

@@ src/u8sd_skid.sv @@
// Two-word output buffer for result words; keeps the byte side moving
// while a result waits. Depends on u8sd_pkg, u8sd_out_if and macro header.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_assert.svh"

module u8sd_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u8sd_pkg::res_t push_word,
    output logic           space_ok,
    u8sd_out_if.source     chars
);
    import u8sd_pkg::*;

    logic [1:0] count_reg, count_next;
    res_t       head_reg, head_next;
    res_t       spare_reg, spare_next;
    logic       pop;

    assign pop      = (count_reg != 2'd0) && chars.ready;
    assign space_ok = (count_reg != 2'd2);

    // Buffer update
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        spare_next = spare_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0) head_next = push_word;
            else                   spare_next = push_word;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            head_next  = spare_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = push_word;
            end
            else
            begin
                head_next  = spare_reg;
                spare_next = push_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload words need no reset
    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign chars.valid         = (count_reg != 2'd0);
    assign chars.code_point    = head_reg.code_point;
    assign chars.char_position = head_reg.char_position;
    assign chars.status        = head_reg.status;
    assign chars.string_done   = head_reg.string_done;

    // Checks
    `U8SD_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= 2'd2)
    `U8SD_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, count_reg != 2'd2)
    `U8SD_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push,
                      count_reg == $past(count_reg) - 2'd1)

endmodule

@@ src/utf8_stream_decoder_top.sv @@
// UTF-8 stream decoder: one raw byte in per word on "bytes", at most one
// character or end-of-string report out per word on "chars".
// Accepts one byte every cycle while the output buffer has room; the
// result of a byte is registered in that buffer and shown on "chars"
// once earlier results are taken. Throughput is one byte per cycle while
// the buffer has room, set by the state update in u8sd_core.
// Continuation bytes are taken unchecked; non-lead bytes met with nothing
// pending are dropped without a result. A byte with string_end set always
// gives a result (character, truncated or empty end) and clears the state.
// When the receiver stalls, results wait in a two-word buffer; bytes are
// still taken until both words are full, then ready drops.
// Reset (rst_n low, asynchronous) clears the pending count, accumulator,
// character counter and buffer; ready is high right after reset.
// Depends on u8sd_pkg, u8sd_in_if, u8sd_out_if, u8sd_core, u8sd_skid.
`timescale 1ns / 1ps

module utf8_stream_decoder_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    u8sd_in_if.sink    bytes,
    u8sd_out_if.source chars
);
    import u8sd_pkg::*;

    logic space_ok;
    logic push;
    res_t push_word;

    u8sd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .space_ok  (space_ok),
        .push      (push),
        .push_word (push_word)
    );

    u8sd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .space_ok  (space_ok),
        .chars     (chars)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for utf8_stream_decoder_top: drives byte words, predicts every
// character and end-of-string word and checks them in order. Depends on u8sd_pkg,
// u8sd_in_if, u8sd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import u8sd_pkg::*;

    localparam int COUNT_BITS  = 16;
    localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_WAIT  = 10;

    logic clk;
    logic rst_n;

    u8sd_in_if  byte_ch ();
    u8sd_out_if char_ch ();

    utf8_stream_decoder_top #(
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .chars (char_ch)
    );

    // Decoder state mirrored by the predictor
    logic [PEND_W-1:0]     pend_cnt;
    logic [CP_W-1:0]       cp_acc;
    logic [COUNT_BITS-1:0] char_count;

    res_t       expected_chars[$];
    logic [7:0] str_bytes[$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Prints one line per mismatch and counts it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, exp);
        mismatches++;
    endtask

    // Advances the mirrored state by one byte; has_res tells whether a word comes out
    function automatic void decode_byte(input logic [7:0] b, input logic last,
                                        output logic has_res, output res_t r);
        logic       done;
        int         seq_len;
        logic [7:0] mask;
        done    = 1'b0;
        has_res = 1'b0;
        r       = '0;
        if (pend_cnt == '0)
        begin
            casez (b)
                8'b0???????: begin seq_len = 1; mask = 8'h7F; end
                8'b110?????: begin seq_len = 2; mask = 8'h1F; end
                8'b1110????: begin seq_len = 3; mask = 8'h0F; end
                8'b11110???: begin seq_len = 4; mask = 8'h07; end
                8'b111110??: begin seq_len = 5; mask = 8'h03; end
                8'b1111110?: begin seq_len = 6; mask = 8'h01; end
                default:     begin seq_len = 0; mask = 8'h00; end
            endcase
            // stray continuation, 0xFE and 0xFF leave the state alone
            if (seq_len != 0)
            begin
                cp_acc   = CP_W'(b & mask);
                pend_cnt = PEND_W'(seq_len - 1);
                done     = (seq_len == 1);
            end
        end
        else
        begin
            // any byte counts as a continuation here, unchecked
            cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
            pend_cnt = pend_cnt - 1'b1;
            done     = (pend_cnt == '0);
        end

        if (done && char_count != '1)
            char_count = char_count + 1'b1;

        if (done)
        begin
            has_res         = 1'b1;
            r.code_point    = cp_acc;
            r.char_position = POS_W'(char_count);
            r.status        = ST_CHAR;
            r.string_done   = last;
        end
        else if (last)
        begin
            has_res         = 1'b1;
            r.code_point    = '0;
            r.char_position = POS_W'(char_count);
            r.status        = (pend_cnt != '0) ? ST_TRUNC : ST_EMPTY;
            r.string_done   = 1'b1;
        end

        if (last)
        begin
            pend_cnt   = '0;
            cp_acc     = '0;
            char_count = '0;
        end
    endfunction

    // Predict on accepted bytes, check accepted result words
    always @(posedge clk)
    begin
        logic has_res;
        res_t pred;
        res_t exp;
        if (byte_ch.valid && byte_ch.ready)
        begin
            decode_byte(byte_ch.in_byte, byte_ch.string_end, has_res, pred);
            if (has_res)
                expected_chars.push_back(pred);
        end
        if (char_ch.valid && char_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected result word, code_point", 32'(char_ch.code_point), 0);
            end
            else
            begin
                exp = expected_chars.pop_front();
                if (char_ch.code_point !== exp.code_point)
                    report_mismatch("code_point", 32'(char_ch.code_point), 32'(exp.code_point));
                if (char_ch.char_position !== exp.char_position)
                    report_mismatch("char_position", 32'(char_ch.char_position),
                                    32'(exp.char_position));
                if (char_ch.status !== exp.status)
                    report_mismatch("status", 32'(char_ch.status), 32'(exp.status));
                if (char_ch.string_done !== exp.string_done)
                    report_mismatch("string_done", 32'(char_ch.string_done),
                                    32'(exp.string_done));
            end
        end
    end

    // Receiver: long hold-off when asked, otherwise random stalls
    initial
    begin
        char_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                char_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                char_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles where no word moves
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL utf8_stream_decoder_top");
        $finish;
    end

    // Offers one byte word and returns once it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.in_byte    <= b;
        byte_ch.string_end <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    // Appends one character of the given length; trunc drops the final byte of a multi-byte one
    task automatic add_char(input int seq_len, input bit trunc);
        logic [31:0] v;
        v = $urandom;
        case (seq_len)
            1:       str_bytes.push_back({1'b0, v[6:0]});
            2:       str_bytes.push_back({3'b110, v[4:0]});
            3:       str_bytes.push_back({4'b1110, v[3:0]});
            4:       str_bytes.push_back({5'b11110, v[2:0]});
            5:       str_bytes.push_back({6'b111110, v[1:0]});
            default: str_bytes.push_back({7'b1111110, v[0]});
        endcase
        for (int k = 1; k < seq_len; k++)
        begin
            // now and then a random byte, which need not be 10xxxxxx
            if ($urandom_range(99) < 5)
                str_bytes.push_back(8'($urandom_range(255)));
            else
                str_bytes.push_back({2'b10, 6'($urandom_range(63))});
        end
        if (trunc && seq_len > 1)
            void'(str_bytes.pop_back());
    endtask

    // Sends the collected string with string_end on its last byte
    task automatic send_string();
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    // Field extremes, every sequence length and each corner of the decode rules
    task automatic test_directed();
        logic [7:0] seq[$];
        send_idle_pct = 13;
        recv_idle_pct = 57;
        seq = '{8'h00, 8'h7F,                                   // U+0000 and top ASCII
                8'hC3, 8'h41,                                   // ASCII taken as continuation
                8'hE2, 8'h82, 8'hAC,
                8'hF0, 8'h9F, 8'h98, 8'h80,
                8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,       // largest code point
                8'hFE, 8'hFF};                                  // ignored lead bytes
        foreach (seq[i])
            send_byte(seq[i], 1'b0);
        send_byte(8'h80, 1'b1);     // stray continuation ends string: nothing pending
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);     // end mid-sequence
        send_byte(8'hC3, 1'b1);     // end on a multi-byte lead
        send_byte(8'h41, 1'b1);     // end on a completed character
        send_byte(8'hFF, 1'b1);     // one-byte string that is only an invalid lead
    endtask

    // Mostly well-formed strings with random content, some noise and cut sequences
    task automatic test_random_strings(input int n_bytes, input int send_pct,
                                       input int recv_pct);
        int sent;
        int n_chars;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        while (sent < n_bytes)
        begin
            n_chars = $urandom_range(1, 12);
            repeat (n_chars)
            begin
                if ($urandom_range(99) < 8)
                    str_bytes.push_back(8'($urandom_range(255)));
                else
                    add_char($urandom_range(1, 6), $urandom_range(99) < 5);
            end
            sent += str_bytes.size();
            send_string();
        end
    endtask

    // Receiver holds off long enough for the decoder to fill and drop ready
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 100;
        repeat (40)
            add_char(1, 1'b0);
        add_char(3, 1'b0);
        send_string();
    endtask

    // One long string that carries the character counter past its low byte
    task automatic test_long_string();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (300)
        begin
            if ($urandom_range(99) < 90)
                add_char(1, 1'b0);
            else
                add_char($urandom_range(2, 6), 1'b0);
        end
        send_string();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.in_byte    = '0;
        byte_ch.string_end = 1'b0;
        pend_cnt           = '0;
        cp_acc             = '0;
        char_count         = '0;
        mismatches         = 0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_cycles        = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_strings(450, 13, 57);
        test_random_strings(450, 57, 13);
        test_backpressure();
        test_long_string();
        test_random_strings(450, 0, 0);

        // drain, then allow the output buffer latency
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("PASS utf8_stream_decoder_top");
        else
            $display("FAIL utf8_stream_decoder_top");
        $finish;
    end

endmodule

@@ utf8_stream_decoder_top.f @@
+incdir+src
src/u8sd_pkg.sv
src/u8sd_in_if.sv
src/u8sd_out_if.sv
src/u8sd_core.sv
src/u8sd_skid.sv
src/utf8_stream_decoder_top.sv
sim/tb_top.sv
